// ----- design/swls_pkg.sv -----
// swls_pkg: types and constants for the sliding-window latency statistics block
// no dependencies; imported by sliding_window_latency_stats
package swls_pkg;

    localparam int MAX_WINDOW      = 64;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int SAMPLE_BITS     = 24;
    localparam int TREND_MIN_COUNT = 10;
    localparam int SUM_W           = 30;
    localparam int S2_W            = 54;
    localparam int PROD_W          = 48;
    localparam int NSQ_W           = 55;
    localparam int CMP_W           = 60;
    localparam int DIV_W           = 64;
    localparam int DEV_W           = 28;
    localparam int OUT_W           = 136;
    localparam int ADDR_W          = 3;

    localparam logic [CNT_W-1:0] WINDOW_LEN_RESET = 7'd64;
    localparam logic             REG_WINDOW_LEN   = 1'b0;

    localparam logic [1:0] TREND_UNDEF = 2'd0;
    localparam logic [1:0] TREND_STABLE = 2'd1;
    localparam logic [1:0] TREND_UP = 2'd2;
    localparam logic [1:0] TREND_DOWN = 2'd3;

    localparam logic [DIV_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DROP,
        ST_DEL,
        ST_APPEND,
        ST_INS,
        ST_INS_LAST,
        ST_DIV,
        ST_DIV_END,
        ST_SCAN,
        ST_MED0,
        ST_MED1,
        ST_MED2,
        ST_SQRT,
        ST_SPK_SQ,
        ST_SPK_CMP,
        ST_TRD_SQ,
        ST_TRD_CMP,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_OLD,
        DIV_NEW
    } div_kind_t;

endpackage

// ----- design/sliding_window_latency_stats.sv -----
// sliding_window_latency_stats: ring of samples plus sorted copy, both in
// synchronous memories, walked by one sequencer with a shared divider and square root
// depends on swls_pkg
//
//  channel   | dir | beat contents
//  ----------+-----+-------------------------------------------------------
//  s_axis    | in  | tdata: sample; tuser: func (1 = clear)
//  m_axis    | out | tdata: count, mean, minimum, maximum, median,
//            |     |        deviation_q4, trend, spike
//  apb       | in  | window_len at byte address 0
//
// one item at a time; an add makes up to two walks of the
// sorted memory, one walk of the ring, up to four 64-step divides and a
// 32-step square root, one memory read port per walk. no clearing pass
// after reset.
// a finished beat waits in the output register while the next item is taken.
module sliding_window_latency_stats
    import swls_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // [23:0] sample
    input  logic [0:0]          s_tuser,   // [0] func
    output logic                m_tvalid,
    input  logic                m_tready,
    // [6:0] count, [30:7] mean, [54:31] minimum, [78:55] maximum,
    // [102:79] median, [130:103] deviation_q4, [132:131] trend, [133] spike
    output logic [OUT_W-1:0]    m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] srt_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] ring_q;
    logic [SAMPLE_BITS-1:0] srt_q;

    state_t                 state_reg, state_next;
    div_kind_t              div_kind_reg, div_kind_next;
    logic [CNT_W-1:0]       wlen_reg;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [IDX_W-1:0]       oldest_reg, oldest_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [SAMPLE_BITS-1:0] rem_val_reg, rem_val_next;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic [CNT_W-1:0]       rem_cnt_reg, rem_cnt_next;
    logic                   dvld_reg, dvld_next;
    logic [CNT_W-1:0]       didx_reg, didx_next;
    logic                   sqv_reg, sqv_next;
    logic [PROD_W-1:0]      sq_reg, sq_next;
    logic [S2_W-1:0]        s2_reg, s2_next;
    logic [SUM_W-1:0]       osum_reg, osum_next;
    logic [SUM_W-1:0]       rsum_reg, rsum_next;
    logic [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [SAMPLE_BITS-1:0] med_reg, med_next;
    logic [SAMPLE_BITS-1:0] med_hi_reg, med_hi_next;
    logic [SAMPLE_BITS-1:0] latest_reg, latest_next;
    logic [SAMPLE_BITS-1:0] a_reg, a_next;
    logic [SAMPLE_BITS-1:0] b_reg, b_next;
    logic [DEV_W-1:0]       dev_reg, dev_next;
    logic [1:0]             trend_reg, trend_next;
    logic                   spike_reg, spike_next;
    logic                   spk_pos_reg, spk_pos_next;
    logic [DIV_W-1:0]       div_num_reg, div_num_next;
    logic [CNT_W-1:0]       div_den_reg, div_den_next;
    logic [IDX_W-1:0]       div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]       div_q_reg, div_q_next;
    logic [CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic [DIV_W-1:0]       sq_v_reg, sq_v_next;
    logic [DIV_W-1:0]       root_reg, root_next;
    logic [DIV_W-1:0]       bit_reg, bit_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;

    logic [CNT_W-1:0]       eff_len;
    logic [CNT_W-1:0]       half;
    logic [IDX_W-1:0]       ring_ra, srt_ra, ring_wa, srt_wa;
    logic                   ring_we, srt_we;
    logic [SAMPLE_BITS-1:0] ring_wd, srt_wd;
    logic [SAMPLE_BITS-1:0] mul_a;
    logic [PROD_W-1:0]      prod;
    logic [NSQ_W-1:0]       nsq;
    logic                   cfg_wr;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W-1:0] p);
        logic [CNT_W-1:0] q;
        begin
            q = p;
            if (q >= CNT_W'(MAX_WINDOW))
            begin
                q = q - CNT_W'(MAX_WINDOW);
            end
            return q[IDX_W-1:0];
        end
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_WINDOW_LEN);
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? 32'(wlen_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WINDOW_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            wlen_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (wlen_reg > CNT_W'(MAX_WINDOW))
        begin
            eff_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = wlen_reg;
        end
    end

    assign half = fill_reg >> 1;
    assign prod = PROD_W'(mul_a) * PROD_W'(mul_a);
    assign nsq  = NSQ_W'(sq_reg) * NSQ_W'(fill_reg);

    // memories
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_wa] <= ring_wd;
        end
        ring_q <= ring_mem[ring_ra];
    end

    always_ff @(posedge clk)
    begin
        if (srt_we)
        begin
            srt_mem[srt_wa] <= srt_wd;
        end
        srt_q <= srt_mem[srt_ra];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            dvld_reg     <= 1'b0;
            sqv_reg      <= 1'b0;
            found_reg    <= 1'b0;
            rem_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
            div_kind_reg <= DIV_MEAN;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            oldest_reg   <= oldest_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
            dvld_reg     <= dvld_next;
            sqv_reg      <= sqv_next;
            found_reg    <= found_next;
            rem_cnt_reg  <= rem_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            div_kind_reg <= div_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        rem_val_reg <= rem_val_next;
        iss_reg     <= iss_next;
        didx_reg    <= didx_next;
        sq_reg      <= sq_next;
        s2_reg      <= s2_next;
        osum_reg    <= osum_next;
        rsum_reg    <= rsum_next;
        mean_reg    <= mean_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        med_reg     <= med_next;
        med_hi_reg  <= med_hi_next;
        latest_reg  <= latest_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        dev_reg     <= dev_next;
        trend_reg   <= trend_next;
        spike_reg   <= spike_next;
        spk_pos_reg <= spk_pos_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        sq_v_reg    <= sq_v_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        logic [CNT_W-1:0]       div_r;
        logic                   div_ge;
        logic [DIV_W-1:0]       sq_t;
        logic [DIV_W-1:0]       root_new;
        logic [SAMPLE_BITS:0]   med_sum;
        logic [CMP_W-1:0]       t9;

        state_next    = state_reg;
        div_kind_next = div_kind_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        sum_next      = sum_reg;
        x_next        = x_reg;
        rem_val_next  = rem_val_reg;
        found_next    = found_reg;
        iss_next      = iss_reg;
        rem_cnt_next  = rem_cnt_reg;
        dvld_next     = dvld_reg;
        didx_next     = didx_reg;
        sqv_next      = sqv_reg;
        sq_next       = sq_reg;
        s2_next       = s2_reg;
        osum_next     = osum_reg;
        rsum_next     = rsum_reg;
        mean_next     = mean_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        med_next      = med_reg;
        med_hi_next   = med_hi_reg;
        latest_next   = latest_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        dev_next      = dev_reg;
        trend_next    = trend_reg;
        spike_next    = spike_reg;
        spk_pos_next  = spk_pos_reg;
        div_num_next  = div_num_reg;
        div_den_next  = div_den_reg;
        div_rem_next  = div_rem_reg;
        div_q_next    = div_q_reg;
        div_cnt_next  = div_cnt_reg;
        sq_v_next     = sq_v_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;

        ring_ra  = wrap_idx(CNT_W'(oldest_reg) + iss_reg);
        srt_ra   = iss_reg[IDX_W-1:0];
        ring_we  = 1'b0;
        ring_wa  = wrap_idx(CNT_W'(oldest_reg) + fill_reg);
        ring_wd  = x_reg;
        srt_we   = 1'b0;
        srt_wa   = '0;
        srt_wd   = x_reg;
        mul_a    = '0;

        div_r    = {div_rem_reg, div_num_reg[DIV_W-1]};
        div_ge   = (div_r >= div_den_reg);
        sq_t     = root_reg + bit_reg;
        root_new = root_reg >> 1;
        med_sum  = (SAMPLE_BITS+1)'(med_hi_reg) + (SAMPLE_BITS+1)'(srt_q);
        t9       = CMP_W'({s2_reg, 3'b000}) + CMP_W'(s2_reg);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                ring_ra = oldest_reg;
                if (s_tvalid)
                begin
                    x_next = s_tdata[SAMPLE_BITS-1:0];
                    if (s_tuser[0])
                    begin
                        fill_next   = '0;
                        oldest_next = '0;
                        sum_next    = '0;
                        state_next  = ST_OUT;
                    end
                    else if (fill_reg >= eff_len && fill_reg != '0)
                    begin
                        state_next = ST_DROP;
                    end
                    else
                    begin
                        state_next = ST_APPEND;
                    end
                end
            end

            ST_DROP:
            begin
                rem_val_next = ring_q;
                sum_next     = sum_reg - SUM_W'(ring_q);
                oldest_next  = wrap_idx(CNT_W'(oldest_reg) + CNT_W'(1));
                fill_next    = fill_reg - CNT_W'(1);
                found_next   = 1'b0;
                iss_next     = '0;
                rem_cnt_next = fill_reg;
                dvld_next    = 1'b0;
                state_next   = ST_DEL;
            end

            // remove one copy of the dropped sample, shifting the rest down
            ST_DEL:
            begin
                if (rem_cnt_reg != '0)
                begin
                    srt_ra       = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg + CNT_W'(1);
                    rem_cnt_next = rem_cnt_reg - CNT_W'(1);
                    dvld_next    = 1'b1;
                    didx_next    = iss_reg;
                end
                else
                begin
                    dvld_next = 1'b0;
                end
                if (dvld_reg)
                begin
                    if (found_reg)
                    begin
                        srt_we = 1'b1;
                        srt_wa = wrap_idx(didx_reg - CNT_W'(1));
                        srt_wd = srt_q;
                    end
                    else if (srt_q == rem_val_reg)
                    begin
                        found_next = 1'b1;
                    end
                end
                if (rem_cnt_reg == '0 && !dvld_reg)
                begin
                    state_next = ST_APPEND;
                end
            end

            ST_APPEND:
            begin
                ring_we   = 1'b1;
                sum_next  = sum_reg + SUM_W'(x_reg);
                fill_next = fill_reg + CNT_W'(1);
                if (fill_reg == '0)
                begin
                    state_next = ST_INS_LAST;
                end
                else
                begin
                    iss_next     = fill_reg - CNT_W'(1);
                    rem_cnt_next = fill_reg;
                    dvld_next    = 1'b0;
                    state_next   = ST_INS;
                end
            end

            // insertion walking down from the top entry
            ST_INS:
            begin
                if (rem_cnt_reg != '0)
                begin
                    srt_ra       = iss_reg[IDX_W-1:0];
                    iss_next     = iss_reg - CNT_W'(1);
                    rem_cnt_next = rem_cnt_reg - CNT_W'(1);
                    dvld_next    = 1'b1;
                    didx_next    = iss_reg;
                end
                else
                begin
                    dvld_next = 1'b0;
                end
                if (dvld_reg)
                begin
                    srt_we = 1'b1;
                    srt_wa = wrap_idx(didx_reg + CNT_W'(1));
                    if (srt_q > x_reg)
                    begin
                        srt_wd = srt_q;
                        if (didx_reg == '0)
                        begin
                            state_next = ST_INS_LAST;
                        end
                    end
                    else
                    begin
                        srt_wd        = x_reg;
                        div_num_next  = DIV_W'(sum_reg);
                        div_den_next  = fill_reg;
                        div_rem_next  = '0;
                        div_q_next    = '0;
                        div_cnt_next  = CNT_W'(DIV_W);
                        div_kind_next = DIV_MEAN;
                        state_next    = ST_DIV;
                    end
                end
            end

            ST_INS_LAST:
            begin
                srt_we        = 1'b1;
                srt_wa        = '0;
                srt_wd        = x_reg;
                div_num_next  = DIV_W'(sum_reg);
                div_den_next  = fill_reg;
                div_rem_next  = '0;
                div_q_next    = '0;
                div_cnt_next  = CNT_W'(DIV_W);
                div_kind_next = DIV_MEAN;
                state_next    = ST_DIV;
            end

            // restoring divide, one quotient bit a cycle
            ST_DIV:
            begin
                div_rem_next = div_ge ? IDX_W'(div_r - div_den_reg) : div_r[IDX_W-1:0];
                div_num_next = div_num_reg << 1;
                div_q_next   = {div_q_reg[DIV_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg - CNT_W'(1);
                if (div_cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DIV_END;
                end
            end

            ST_DIV_END:
            begin
                unique case (div_kind_reg)
                    DIV_MEAN:
                    begin
                        mean_next    = div_q_reg[SAMPLE_BITS-1:0];
                        iss_next     = '0;
                        rem_cnt_next = fill_reg;
                        dvld_next    = 1'b0;
                        sqv_next     = 1'b0;
                        s2_next      = '0;
                        osum_next    = '0;
                        rsum_next    = '0;
                        state_next   = ST_SCAN;
                    end
                    DIV_VAR:
                    begin
                        sq_v_next  = div_q_reg;
                        root_next  = '0;
                        bit_next   = SQRT_TOP;
                        state_next = ST_SQRT;
                    end
                    DIV_OLD:
                    begin
                        a_next        = div_q_reg[SAMPLE_BITS-1:0];
                        div_num_next  = DIV_W'(rsum_reg);
                        div_den_next  = fill_reg - half;
                        div_rem_next  = '0;
                        div_q_next    = '0;
                        div_cnt_next  = CNT_W'(DIV_W);
                        div_kind_next = DIV_NEW;
                        state_next    = ST_DIV;
                    end
                    DIV_NEW:
                    begin
                        b_next     = div_q_reg[SAMPLE_BITS-1:0];
                        state_next = ST_TRD_SQ;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // walk the ring oldest first: min, max, squared deviations, half sums
            ST_SCAN:
            begin
                if (rem_cnt_reg != '0)
                begin
                    iss_next     = iss_reg + CNT_W'(1);
                    rem_cnt_next = rem_cnt_reg - CNT_W'(1);
                    dvld_next    = 1'b1;
                    didx_next    = iss_reg;
                end
                else
                begin
                    dvld_next = 1'b0;
                end
                if (dvld_reg)
                begin
                    mul_a    = (ring_q >= mean_reg) ? ring_q - mean_reg : mean_reg - ring_q;
                    sq_next  = prod;
                    sqv_next = 1'b1;
                    if (didx_reg == '0 || ring_q < min_reg)
                    begin
                        min_next = ring_q;
                    end
                    if (didx_reg == '0 || ring_q > max_reg)
                    begin
                        max_next = ring_q;
                    end
                    if (didx_reg < half)
                    begin
                        osum_next = osum_reg + SUM_W'(ring_q);
                    end
                    else
                    begin
                        rsum_next = rsum_reg + SUM_W'(ring_q);
                    end
                    latest_next = ring_q;
                end
                else
                begin
                    sqv_next = 1'b0;
                end
                if (sqv_reg)
                begin
                    s2_next = s2_reg + S2_W'(sq_reg);
                end
                if (rem_cnt_reg == '0 && !dvld_reg && !sqv_reg)
                begin
                    state_next = ST_MED0;
                end
            end

            ST_MED0:
            begin
                srt_ra     = half[IDX_W-1:0];
                state_next = ST_MED1;
            end

            ST_MED1:
            begin
                med_hi_next = srt_q;
                srt_ra      = wrap_idx(half - CNT_W'(1));
                state_next  = ST_MED2;
            end

            ST_MED2:
            begin
                if (fill_reg[0])
                begin
                    med_next = med_hi_reg;
                end
                else
                begin
                    med_next = med_sum[SAMPLE_BITS:1];
                end
                if (fill_reg >= CNT_W'(2))
                begin
                    div_num_next  = DIV_W'({s2_reg, 8'h00});
                    div_den_next  = fill_reg;
                    div_rem_next  = '0;
                    div_q_next    = '0;
                    div_cnt_next  = CNT_W'(DIV_W);
                    div_kind_next = DIV_VAR;
                    state_next    = ST_DIV;
                end
                else
                begin
                    dev_next   = '0;
                    state_next = ST_SPK_SQ;
                end
            end

            // integer square root, two bits of the radicand a cycle
            ST_SQRT:
            begin
                if (sq_v_reg >= sq_t)
                begin
                    sq_v_next = sq_v_reg - sq_t;
                    root_new  = (root_reg >> 1) + bit_reg;
                end
                root_next = root_new;
                bit_next  = bit_reg >> 2;
                if (bit_reg == DIV_W'(1))
                begin
                    dev_next   = root_new[DEV_W-1:0];
                    state_next = ST_SPK_SQ;
                end
            end

            ST_SPK_SQ:
            begin
                spk_pos_next = (latest_reg > mean_reg);
                mul_a        = latest_reg - mean_reg;
                sq_next      = prod;
                state_next   = ST_SPK_CMP;
            end

            ST_SPK_CMP:
            begin
                spike_next = spk_pos_reg && (CMP_W'(nsq) > CMP_W'({s2_reg, 2'b00}));
                if (fill_reg >= CNT_W'(TREND_MIN_COUNT))
                begin
                    div_num_next  = DIV_W'(osum_reg);
                    div_den_next  = half;
                    div_rem_next  = '0;
                    div_q_next    = '0;
                    div_cnt_next  = CNT_W'(DIV_W);
                    div_kind_next = DIV_OLD;
                    state_next    = ST_DIV;
                end
                else
                begin
                    trend_next = TREND_UNDEF;
                    state_next = ST_OUT;
                end
            end

            ST_TRD_SQ:
            begin
                mul_a      = (b_reg > a_reg) ? b_reg - a_reg : a_reg - b_reg;
                sq_next    = prod;
                state_next = ST_TRD_CMP;
            end

            ST_TRD_CMP:
            begin
                if (b_reg > a_reg && CMP_W'({nsq, 2'b00}) > t9)
                begin
                    trend_next = TREND_UP;
                end
                else if (a_reg > b_reg && CMP_W'({nsq, 2'b00}) > t9)
                begin
                    trend_next = TREND_DOWN;
                end
                else
                begin
                    trend_next = TREND_STABLE;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (fill_reg == '0)
                    begin
                        m_tdata_next = '0;
                    end
                    else
                    begin
                        m_tdata_next = {2'b00, spike_reg, trend_reg, dev_reg, med_reg,
                                        max_reg, min_reg, mean_reg, fill_reg};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
